### sv/stt_pkg.sv
// shared types, codes and character helpers for the source text tokenizer
`default_nettype none

package stt_pkg;

  // token kind codes
  localparam logic [3:0] KIND_ID        = 4'd0;
  localparam logic [3:0] KIND_INT       = 4'd1;
  localparam logic [3:0] KIND_FLOAT     = 4'd2;
  localparam logic [3:0] KIND_STRING    = 4'd3;
  localparam logic [3:0] KIND_EQUALS    = 4'd4;
  localparam logic [3:0] KIND_SEMI      = 4'd5;
  localparam logic [3:0] KIND_LPAREN    = 4'd6;
  localparam logic [3:0] KIND_RPAREN    = 4'd7;
  localparam logic [3:0] KIND_LBRACE    = 4'd8;
  localparam logic [3:0] KIND_RBRACE    = 4'd9;
  localparam logic [3:0] KIND_COMMA     = 4'd10;
  localparam logic [3:0] KIND_BAD_NUM   = 4'd11;
  localparam logic [3:0] KIND_EOF       = 4'd12;
  localparam logic [3:0] KIND_UNKNOWN   = 4'd13;
  localparam logic [3:0] KIND_OPEN_STR  = 4'd14;

  // scanner modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ID   = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_STR  = 2'd3;

  // number classifier states
  localparam logic [2:0] NC_INT      = 3'd0;
  localparam logic [2:0] NC_DOT      = 3'd1;
  localparam logic [2:0] NC_FRAC     = 3'd2;
  localparam logic [2:0] NC_EXP_MARK = 3'd3;
  localparam logic [2:0] NC_EXP      = 3'd4;
  localparam logic [2:0] NC_BAD      = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_E_UP   = 8'h45;
  localparam logic [7:0] CH_E_LOW  = 8'h65;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  // all tokens caused by one input item
  typedef struct packed {
    logic [1:0]       count;
    token_t [2:0]     tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  // number classifier transition
  function automatic logic [2:0] number_next(input logic [2:0] s, input logic [7:0] c);
    logic d;
    logic e;
    d = is_digit(c);
    e = (c == CH_E_UP) || (c == CH_E_LOW);
    case (s)
      NC_INT:      return d ? NC_INT : (c == CH_DOT) ? NC_DOT : e ? NC_EXP_MARK : NC_BAD;
      NC_DOT:      return d ? NC_FRAC : NC_BAD;
      NC_FRAC:     return d ? NC_FRAC : e ? NC_EXP_MARK : NC_BAD;
      NC_EXP_MARK: return d ? NC_EXP : NC_BAD;
      NC_EXP:      return d ? NC_EXP : NC_BAD;
      default:     return NC_BAD;
    endcase
  endfunction

  function automatic logic [3:0] number_kind(input logic [2:0] s);
    case (s)
      NC_INT:          return KIND_INT;
      NC_FRAC, NC_EXP: return KIND_FLOAT;
      default:         return KIND_BAD_NUM;
    endcase
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    case (c)
      CH_EQUALS: return KIND_EQUALS;
      CH_SEMI:   return KIND_SEMI;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_COMMA:  return KIND_COMMA;
      default:   return KIND_UNKNOWN;
    endcase
  endfunction

endpackage

`default_nettype wire

### sv/stt_front.sv
// front end: accepts bytes, runs the scanner automaton, builds token bundles
`default_nettype none

module stt_front import stt_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = 65536,
  localparam int unsigned POS_W = $clog2(MAX_TEXT_BYTES)
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_text,
  input  wire qstat_t     qstat,
  output      logic       push,
  output      bundle_t    bundle,
  output      logic       done
);

  logic [1:0]       mode, mode_next;
  logic [2:0]       nc, nc_next;
  logic [POS_W-1:0] tok_begin, tok_begin_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             fin, fin_next;

  logic             accept;
  logic [1:0]       n;
  token_t [2:0]     tok;
  logic             consumed;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    if (p == POS_W'(MAX_TEXT_BYTES - 1)) return '0;
    return p + 1'b1;
  endfunction

  // length from b up to e, modulo the text size
  function automatic logic [15:0] wrap_len(input logic [POS_W-1:0] e,
                                           input logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    if (e >= b) d = {1'b0, e} - {1'b0, b};
    else d = {1'b0, e} + (POS_W+1)'(MAX_TEXT_BYTES) - {1'b0, b};
    return 16'(d[POS_W-1:0]);
  endfunction

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (n != 2'd0);
  assign bundle   = '{count: n, tok: tok};
  assign done     = fin;

  // scanner step for one byte
  always_comb begin
    mode_next      = mode;
    nc_next        = nc;
    tok_begin_next = tok_begin;
    pos_next       = pos;
    fin_next       = fin;
    n              = 2'd0;
    tok            = '0;
    consumed       = 1'b0;
    if (!fin) begin
      if (char_code != CH_NUL) begin
        case (mode)
          MODE_STR: begin
            if (char_code == CH_QUOTE) begin
              tok[n] = '{KIND_STRING, 16'(tok_begin), wrap_len(pos, tok_begin)};
              n = n + 2'd1;
              mode_next = MODE_IDLE;
            end
            consumed = 1'b1;
          end
          MODE_ID: begin
            if (is_alnum(char_code) || char_code == CH_UNDER) begin
              consumed = 1'b1;
            end else begin
              tok[n] = '{KIND_ID, 16'(tok_begin), wrap_len(pos, tok_begin)};
              n = n + 2'd1;
              mode_next = MODE_IDLE;
              nc_next = NC_INT;
            end
          end
          MODE_NUM: begin
            if (is_alnum(char_code) || char_code == CH_DOT) begin
              nc_next = number_next(nc, char_code);
              consumed = 1'b1;
            end else begin
              tok[n] = '{number_kind(nc), 16'(tok_begin), wrap_len(pos, tok_begin)};
              n = n + 2'd1;
              mode_next = MODE_IDLE;
              nc_next = NC_INT;
            end
          end
          default: ;
        endcase

        // byte handled from idle
        if (!consumed) begin
          if (char_code == CH_SPACE || char_code == CH_NL) begin
            mode_next = mode_next;
          end else if (is_alpha(char_code) || char_code == CH_UNDER) begin
            mode_next = MODE_ID;
            tok_begin_next = pos;
          end else if (is_digit(char_code)) begin
            mode_next = MODE_NUM;
            nc_next = NC_INT;
            tok_begin_next = pos;
          end else if (char_code == CH_QUOTE) begin
            mode_next = MODE_STR;
            tok_begin_next = pos_inc(pos);
          end else begin
            tok[n] = '{punct_kind(char_code), 16'(pos), 16'd1};
            n = n + 2'd1;
          end
        end
        pos_next = pos_inc(pos);
      end

      // end of text: flush pending token, then end token
      if (char_code == CH_NUL || end_of_text) begin
        if (mode_next == MODE_ID) begin
          tok[n] = '{KIND_ID, 16'(tok_begin_next), wrap_len(pos_next, tok_begin_next)};
          n = n + 2'd1;
        end else if (mode_next == MODE_NUM) begin
          tok[n] = '{number_kind(nc_next), 16'(tok_begin_next),
                     wrap_len(pos_next, tok_begin_next)};
          n = n + 2'd1;
        end else if (mode_next == MODE_STR) begin
          tok[n] = '{KIND_OPEN_STR, 16'(tok_begin_next),
                     wrap_len(pos_next, tok_begin_next)};
          n = n + 2'd1;
        end
        mode_next = MODE_IDLE;
        nc_next = NC_INT;
        tok[n] = '{KIND_EOF, 16'(pos_next), 16'd0};
        n = n + 2'd1;
        fin_next = 1'b1;
      end
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      nc        <= NC_INT;
      tok_begin <= '0;
      pos       <= '0;
      fin       <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      nc        <= nc_next;
      tok_begin <= tok_begin_next;
      pos       <= pos_next;
      fin       <= fin_next;
    end
  end

endmodule

`default_nettype wire

### sv/stt_queue.sv
// short bundle queue between scanner front end and token emitter
`default_nettype none

module stt_queue import stt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t wr_bundle,
  input  wire logic    pop,
  output      bundle_t head,
  output      qstat_t  qstat
);

  bundle_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   level;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (level == (QPTR_W+1)'(QDEPTH));
  assign qstat.empty = (level == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_bundle;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

`default_nettype wire

### sv/stt_back.sv
// back end: unpacks bundles, one token per cycle while out_ready is high, registered
`default_nettype none

module stt_back import stt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire qstat_t  qstat,
  output      logic    pop,
  output      logic    out_valid,
  input  wire logic    out_ready,
  output      token_t  out_tok,
  output      logic    out_last
);

  logic [1:0] idx;
  logic       load;
  logic       last_tok;

  assign load     = !qstat.empty && (out_ready || !out_valid);
  assign last_tok = (idx == head.count - 2'd1);
  assign pop      = load && last_tok;

  // output valid and bundle index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (out_ready || !out_valid) begin
      out_valid <= !qstat.empty;
      if (load) idx <= last_tok ? 2'd0 : idx + 2'd1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= head.tok[idx];
      out_last <= last_tok;
    end
  end

endmodule

`default_nettype wire

### sv/source_text_tokenizer_top.sv
// top level of the streaming source text tokenizer
//
// Input channel s_*: one source byte per item, s_tdata[7:0] is the byte and
// s_tlast marks the final byte of the text; a zero byte also ends the text.
// Output channel m_*: one token per item with kind, start offset and length;
// m_tlast marks the last token caused by one input byte.
// A byte is taken every cycle while the bundle queue (4 entries) has room;
// each byte is scanned in the cycle it is accepted and its tokens (up to 3), if
// any, enter the queue as one bundle. The first token reaches m_* via the queue
// and the output register. The emitter sends one token per cycle, so the
// sustained rate is one byte per cycle while bytes produce at most one token each.
// When m_tready is low the output register holds, the queue fills and
// s_tready drops once the queue is full; nothing is lost.
// After the end token every byte is taken and produces nothing until reset.
// Reset (rst, synchronous) empties the queue, clears the offset counter and
// returns the scanner to idle between tokens.
// Offsets wrap modulo MAX_TEXT_BYTES and are given in 16 bits.
`default_nettype none

module source_text_tokenizer_top import stt_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // end_of_text
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
                                      // [35:20] token_length, [39:36] zero
  output      logic        m_tlast    // last_of_run
);

  logic    push;
  logic    pop;
  logic    done;
  bundle_t wr_bundle;
  bundle_t head;
  qstat_t  qstat;
  token_t  out_tok;

  stt_front #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .char_code  (s_tdata),
    .end_of_text(s_tlast),
    .qstat      (qstat),
    .push       (push),
    .bundle     (wr_bundle),
    .done       (done)
  );

  stt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_bundle(wr_bundle),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  stt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_tok  (out_tok),
    .out_last (m_tlast)
  );

  assign m_tdata = {4'd0, out_tok.length, out_tok.start, out_tok.kind};

  // a pushed bundle always carries between one and three tokens
  a_bundle_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (wr_bundle.count != 2'd0))
    else $error("empty bundle pushed");

  // after the end token no byte produces tokens
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !push)
    else $error("token produced after end of text");

  // never pop an empty queue or push into a full one
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty) && !(push && qstat.full))
    else $error("queue overrun or underrun");

  // reset leaves the output idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
